>>> src/pfb_pkg.sv
// Package for the page framebuffer: shared types and command constants.
// No dependencies.
`timescale 1ns / 1ps
package pfb_pkg;
    localparam logic [1:0] FUNC_PIXEL   = 2'd0;
    localparam logic [1:0] FUNC_FILL    = 2'd1;
    localparam logic [1:0] FUNC_REFRESH = 2'd2;
    localparam logic [7:0] CMD_SET_Y = 8'h40;
    localparam logic [7:0] CMD_SET_X = 8'h80;

    // controller -> datapath
    typedef struct packed {
        logic clr_start;   // never driven; the clear sweep starts at reset
        logic clr_step;    // write one clear entry
        logic fill_load;   // latch fill bounds
        logic fill_step;   // write one fill entry (read-modify-write)
        logic fill_rd;     // read the next fill entry
        logic pix_rd;      // read for pixel
        logic pix_wr;      // write back pixel
        logic ref_rd;      // refresh item accepted
        logic ref_out;     // emit refresh result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic fill_empty;
        logic fill_last;
        logic pix_ok;
        logic ref_is_data;
    } t_stat;
endpackage

>>> src/page_framebuffer_draw_refresh.sv
// Top level of the page framebuffer: controller plus datapath.
// Depends on pfb_pkg, pfb_ctrl, pfb_dp, pfb_ram.
`timescale 1ns / 1ps
// Usage:
//  Request channel: drive i_func and the operand ports with start high;
//  a request is taken at a clock edge where start is high and busy low.
//  Result channel: refresh requests (func 2) produce one byte; it appears
//  on o_out_byte/o_is_data/o_frame_end for one cycle with o_valid high,
//  in the cycle right after the request is taken. The receiver cannot stall.
//  Steps of each request, set by the frame store's registered read:
//   pixel request: store read, then modify and write back (no write
//     when off screen);
//   refresh request: store read, then result;
//   fill request: set up, then a read-modify-write of each byte covered
//     (columns x pages), the next byte read while the last is written.
//  Func code 3 is ignored.
//  Reset: i_rst_n low synchronously; afterwards the store is cleared one
//  byte per cycle, all SCREEN_WIDTH*pages bytes, with busy high. The scan
//  sequence restarts at page 0's Y command.
module page_framebuffer_draw_refresh #(
    parameter int SCREEN_WIDTH  = 84,
    parameter int SCREEN_HEIGHT = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic signed [9:0] i_x_pos,
    input  logic signed [9:0] i_y_pos,
    input  logic [9:0]        i_rect_width,
    input  logic [9:0]        i_rect_height,
    input  logic              i_clip_set,
    input  logic              i_color_on,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_is_data,
    output logic              o_frame_end
);
    import pfb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pfb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_func),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    pfb_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_x_pos(i_x_pos), .i_y_pos(i_y_pos),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_clip_set(i_clip_set), .i_color_on(i_color_on),
        .o_stat(stat), .o_out_byte(o_out_byte), .o_is_data(o_is_data),
        .o_frame_end(o_frame_end)
    );

    // result strobe: the cycle the controller emits a refresh byte
    assign o_valid = cmd.ref_out;
endmodule

>>> src/pfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 504
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/pfb_ctrl.sv
// Controller FSM for the page framebuffer.
// Depends on pfb_pkg.
`timescale 1ns / 1ps
module pfb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_func,
    input  pfb_pkg::t_stat i_stat,
    output pfb_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import pfb_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_PIXRD  = 6'b000100,
        S_FLOAD  = 6'b001000,
        S_FRUN   = 6'b010000,
        S_REF    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   acc;

    assign acc = i_start && !o_busy;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    unique case (i_func)
                        FUNC_PIXEL: begin
                            o_cmd.pix_rd = 1'b1;
                            n_state = S_PIXRD;
                        end
                        FUNC_FILL: begin
                            o_cmd.fill_load = 1'b1;
                            n_state = S_FLOAD;
                        end
                        FUNC_REFRESH: begin
                            o_cmd.ref_rd = 1'b1;
                            n_state = S_REF;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // read data is valid here: modify and write back in this cycle when on screen
            S_PIXRD: begin
                o_cmd.pix_wr = i_stat.pix_ok;
                n_state = S_IDLE;
            end
            S_FLOAD: begin
                if (i_stat.fill_empty) n_state = S_IDLE;
                else begin
                    o_cmd.fill_rd = 1'b1;
                    n_state = S_FRUN;
                end
            end
            S_FRUN: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) n_state = S_IDLE;
                else o_cmd.fill_rd = 1'b1;
            end
            S_REF: begin
                o_cmd.ref_out = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end
endmodule

>>> src/pfb_dp.sv
// Datapath for the page framebuffer: frame store, fill walker, scan counters.
// Depends on pfb_pkg and pfb_ram.
`timescale 1ns / 1ps
module pfb_dp #(
    parameter int SCREEN_WIDTH  = 84,
    parameter int SCREEN_HEIGHT = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfb_pkg::t_cmd       i_cmd,
    input  logic signed [9:0]   i_x_pos,
    input  logic signed [9:0]   i_y_pos,
    input  logic [9:0]          i_rect_width,
    input  logic [9:0]          i_rect_height,
    input  logic                i_clip_set,
    input  logic                i_color_on,
    output pfb_pkg::t_stat      o_stat,
    output logic [7:0]          o_out_byte,
    output logic                o_is_data,
    output logic                o_frame_end
);
    import pfb_pkg::*;

    localparam int NUM_PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH     = SCREEN_WIDTH * NUM_PAGES;
    localparam int AW        = $clog2(DEPTH);
    localparam int XW        = $clog2(SCREEN_WIDTH);
    localparam int PW        = $clog2(NUM_PAGES + 1);
    localparam int SW        = $clog2(SCREEN_WIDTH + 2);

    // RAM port wiring
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    pfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // clear sweep
    logic [AW-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_addr <= '0;
        else if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
    end
    assign o_stat.clr_done = (r_clr_addr == AW'(DEPTH - 1));

    // pixel request
    logic          pix_ok;
    logic [AW-1:0] pix_addr;
    logic [7:0]    pix_bit;
    logic [AW-1:0] r_pix_addr;
    logic [7:0]    r_pix_bit;
    logic          r_pix_ok, r_color;

    assign pix_ok = !i_x_pos[9] && !i_y_pos[9]
                    && (i_x_pos < 10'(SCREEN_WIDTH)) && (i_y_pos < 10'(SCREEN_HEIGHT));
    assign pix_addr = AW'(i_x_pos[XW-1:0])
                    + AW'(i_y_pos[9:3]) * AW'(SCREEN_WIDTH);
    assign pix_bit = 8'(1) << i_y_pos[2:0];
    assign o_stat.pix_ok = r_pix_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_rd) begin
            r_pix_addr <= pix_addr;
            r_pix_bit  <= pix_bit;
            r_pix_ok   <= pix_ok;
        end
        if (i_cmd.pix_rd || i_cmd.fill_load) r_color <= i_color_on;
    end

    // fill: bounds computed once, then walk page by page, column by column
    logic signed [11:0] fx0, fy0, fx1, fy1, ex, ey;
    logic [XW-1:0] r_x0, r_x1m, r_fx;
    logic [PW-1:0] r_pg, r_pg1;
    logic [5:0]    r_y0, r_y1m;
    logic          r_empty;
    logic          r_flast;
    logic [AW-1:0] r_frow, r_faddr;
    logic [7:0]    r_fmask;
    logic [7:0]    cur_mask;
    logic [5:0]    lo_b, hi_b;

    always_comb begin
        fx0 = 12'sd0; fy0 = 12'sd0;
        fx1 = 12'(SCREEN_WIDTH); fy1 = 12'(SCREEN_HEIGHT);
        ex = 12'(i_x_pos) + 12'(signed'({1'b0, i_rect_width}));
        ey = 12'(i_y_pos) + 12'(signed'({1'b0, i_rect_height}));
        if (i_clip_set) begin
            if (12'(i_x_pos) > fx0) fx0 = 12'(i_x_pos);
            if (12'(i_y_pos) > fy0) fy0 = 12'(i_y_pos);
            if (ex < fx1) fx1 = ex;
            if (ey < fy1) fy1 = ey;
        end
    end

    // mask for current page: bits from y0 to y1-1 within page
    always_comb begin
        lo_b = (r_y0[5:3] == 3'(r_pg)) ? {3'b0, r_y0[2:0]} : 6'd0;
        hi_b = (r_y1m[5:3] == 3'(r_pg)) ? {3'b0, r_y1m[2:0]} : 6'd7;
        cur_mask = '0;
        for (int b = 0; b < 8; b++)
            if (6'(b) >= lo_b && 6'(b) <= hi_b) cur_mask[b] = 1'b1;
    end

    logic f_last_col, f_last_pg;
    assign f_last_col = (r_fx == r_x1m);
    assign f_last_pg  = (r_pg == r_pg1);
    assign o_stat.fill_empty = r_empty;
    // last flag travels with the entry read, so it marks the entry being written
    assign o_stat.fill_last  = r_flast;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_load) begin
            r_empty <= (fx1 <= fx0) || (fy1 <= fy0);
            r_x0    <= XW'(fx0);
            r_x1m   <= XW'(fx1 - 12'sd1);
            r_fx    <= XW'(fx0);
            r_y0    <= 6'(fy0);
            r_y1m   <= 6'(fy1 - 12'sd1);
            r_pg    <= PW'(fy0 >>> 3);
            r_pg1   <= PW'((fy1 - 12'sd1) >>> 3);
            r_frow  <= AW'(fy0 >>> 3) * AW'(SCREEN_WIDTH);
        end else if (i_cmd.fill_rd) begin
            // issue read for (r_pg, r_fx), then advance
            r_faddr <= r_frow + AW'(r_fx);
            r_fmask <= cur_mask;
            r_flast <= f_last_col && f_last_pg;
            if (f_last_col) begin
                r_fx   <= r_x0;
                r_pg   <= r_pg + PW'(1);
                r_frow <= r_frow + AW'(SCREEN_WIDTH);
            end else begin
                r_fx <= r_fx + XW'(1);
            end
        end
    end

    // refresh scan counters
    logic [PW-1:0] r_spage;
    logic [SW-1:0] r_sslot;
    logic [AW-1:0] r_srow;
    logic [7:0]    r_rbyte;
    logic          r_rdata, r_rend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spage <= '0;
            r_sslot <= '0;
            r_srow  <= '0;
        end else if (i_cmd.ref_rd) begin
            if (r_spage >= PW'(NUM_PAGES)) begin
                r_spage <= '0; r_sslot <= '0; r_srow <= '0;
            end else if (r_sslot >= SW'(SCREEN_WIDTH + 1)) begin
                r_spage <= r_spage + PW'(1);
                r_sslot <= '0;
                r_srow  <= r_srow + AW'(SCREEN_WIDTH);
            end else begin
                r_sslot <= r_sslot + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ref_rd) begin
            r_rdata <= 1'b0;
            r_rend  <= 1'b0;
            if (r_spage >= PW'(NUM_PAGES)) begin
                r_rbyte <= CMD_SET_Y;
                r_rend  <= 1'b1;
            end else if (r_sslot == '0) begin
                r_rbyte <= CMD_SET_Y | 8'(r_spage[PW-1:0] & PW'(7));
            end else if (r_sslot == SW'(1)) begin
                r_rbyte <= CMD_SET_X;
            end else begin
                r_rdata <= 1'b1;
            end
        end
    end
    assign o_stat.ref_is_data = r_rdata;

    always_comb begin
        o_out_byte  = r_rdata ? rdata : r_rbyte;
        o_is_data   = r_rdata;
        o_frame_end = r_rend;
    end

    // RAM port mux
    always_comb begin
        we = 1'b0; waddr = r_clr_addr; wdata = '0;
        raddr = r_srow + AW'(r_sslot - SW'(2));
        priority if (i_cmd.clr_step) begin
            we = 1'b1; waddr = r_clr_addr; wdata = '0;
        end else if (i_cmd.pix_wr) begin
            we = 1'b1; waddr = r_pix_addr;
            wdata = r_color ? (rdata | r_pix_bit) : (rdata & ~r_pix_bit);
        end else if (i_cmd.fill_step) begin
            we = 1'b1; waddr = r_faddr;
            wdata = (rdata & ~r_fmask) | ((r_color ? 8'hFF : 8'h00) & r_fmask);
        end
        if (i_cmd.pix_rd) raddr = pix_addr;
        else if (i_cmd.fill_rd) raddr = r_frow + AW'(r_fx);
    end
endmodule

>>> src/pfb_checker.sv
// Port-level checker for the page framebuffer, bound to the top level.
// Depends on pfb_pkg and page_framebuffer_draw_refresh.
`timescale 1ns / 1ps
module pfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_func,
    input logic       o_valid,
    input logic       o_is_data,
    input logic       o_frame_end
);
    import pfb_pkg::*;

    // a refresh request is followed by a result in the next cycle
    a_ref_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_REFRESH) |=> o_valid)
        else $error("refresh result missing");
    // a result only ever follows a refresh request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_func == FUNC_REFRESH, 1))
        else $error("unrequested result");
    // frame end is a command byte
    a_end_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> !o_is_data)
        else $error("frame end on data byte");
    // block is busy while a result is produced
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result while idle");
endmodule

bind page_framebuffer_draw_refresh pfb_checker u_pfb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_func(i_func), .o_valid(o_valid), .o_is_data(o_is_data),
    .o_frame_end(o_frame_end)
);

>>> tb/page_framebuffer_draw_refresh_tb.sv
// Testbench for page_framebuffer_draw_refresh: directed table plus random requests,
// every refresh byte checked against a typed byte or a testbench store predictor.
// Depends on pfb_pkg and the page_framebuffer_draw_refresh RTL.
`timescale 1ns / 1ps
module page_framebuffer_draw_refresh_tb;
    import pfb_pkg::*;

    localparam int SCR_W = 84;
    localparam int SCR_H = 48;
    localparam int PAGES = (SCR_H + 7) / 8;
    localparam int STORE_BYTES = SCR_W * PAGES;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int NUM_RANDOM = 1630;
    localparam int CYCLE_LIMIT = 5_000_000;

    // One request as driven on the ports, with an optional typed-in result.
    typedef struct {
        logic [1:0]        func;
        logic signed [9:0] x;
        logic signed [9:0] y;
        logic [9:0]        w;
        logic [9:0]        h;
        logic              clip;
        logic              color;
        bit                typed;   // expected byte typed in the table
        logic [7:0]        t_byte;
        logic              t_data;
        logic              t_end;
    } t_req;

    typedef struct {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } t_scan_byte;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_func;
    logic signed [9:0] i_x_pos;
    logic signed [9:0] i_y_pos;
    logic [9:0]        i_rect_width;
    logic [9:0]        i_rect_height;
    logic              i_clip_set;
    logic              i_color_on;
    logic              o_valid;
    logic [7:0]        o_out_byte;
    logic              o_is_data;
    logic              o_frame_end;

    page_framebuffer_draw_refresh dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_x_pos(i_x_pos), .i_y_pos(i_y_pos),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_clip_set(i_clip_set), .i_color_on(i_color_on),
        .o_valid(o_valid), .o_out_byte(o_out_byte),
        .o_is_data(o_is_data), .o_frame_end(o_frame_end)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Predictor state: mirror of the frame store and the scan position.
    logic [7:0] mirror_store [STORE_BYTES];
    int         scan_pg;
    int         scan_sl;
    t_scan_byte pending_bytes[$];
    int         errors;
    int         cycles;

    // Typed-in expectation for the request currently on the ports.
    bit         cur_typed;
    t_scan_byte cur_typed_byte;

    // Clip-aware fill with per-page bit masks; empty intersection leaves the store.
    task automatic fill_mirror(input int cx, input int cy, input int cw, input int ch,
                               input bit clip, input bit on);
        int x0, y0, x1, y1, pg, py, b0, b1, idx;
        logic [7:0] mask;
        x0 = 0; y0 = 0; x1 = SCR_W; y1 = SCR_H;
        if (clip) begin
            if (cx > x0) x0 = cx;
            if (cy > y0) y0 = cy;
            if (cx + cw < x1) x1 = cx + cw;
            if (cy + ch < y1) y1 = cy + ch;
            if (x1 <= x0 || y1 <= y0) return;
        end
        for (pg = y0 / 8; pg <= (y1 - 1) / 8; pg++) begin
            py = pg * 8;
            b0 = (y0 > py) ? y0 - py : 0;
            b1 = (y1 < py + 8) ? y1 - py : 8;
            mask = '0;
            for (int b = b0; b < b1; b++) mask[b] = 1'b1;
            for (int x = x0; x < x1; x++) begin
                idx = pg * SCR_W + x;
                if (idx >= STORE_BYTES) continue;
                mirror_store[idx] = (mirror_store[idx] & ~mask) | ((on ? 8'hFF : 8'h00) & mask);
            end
        end
    endtask

    // Apply one accepted request; returns 1 with the scan byte for refresh requests.
    task automatic apply_request(input logic [1:0] fn, input int x, input int y,
                                 input int w, input int h, input bit clip, input bit on,
                                 output bit has_byte, output t_scan_byte sb);
        int idx;
        has_byte = 1'b0;
        sb = '{8'h00, 1'b0, 1'b0};
        case (fn)
            FUNC_PIXEL: begin
                if (x >= 0 && y >= 0 && x < SCR_W && y < SCR_H) begin
                    idx = x + (y / 8) * SCR_W;
                    mirror_store[idx][y % 8] = on;
                end
            end
            FUNC_FILL: fill_mirror(x, y, w, h, clip, on);
            FUNC_REFRESH: begin
                has_byte = 1'b1;
                if (scan_pg >= PAGES) begin
                    sb = '{CMD_SET_Y, 1'b0, 1'b1};
                    scan_pg = 0;
                    scan_sl = 0;
                end else if (scan_sl == 0) begin
                    sb = '{CMD_SET_Y | 8'(scan_pg), 1'b0, 1'b0};
                    scan_sl = 1;
                end else if (scan_sl == 1) begin
                    sb = '{CMD_SET_X, 1'b0, 1'b0};
                    scan_sl = 2;
                end else begin
                    sb = '{mirror_store[scan_pg * SCR_W + scan_sl - 2], 1'b1, 1'b0};
                    if (scan_sl - 1 >= SCR_W) begin
                        scan_pg++;
                        scan_sl = 0;
                    end else begin
                        scan_sl++;
                    end
                end
            end
            default: ;  // unused code: ignored
        endcase
    endtask

    // Monitor: check results first, then predict for a request taken this edge.
    always @(posedge i_clk) begin
        bit         hb;
        t_scan_byte sb, exp_b;
        if (i_rst_n && o_valid) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected result byte=%h data=%b end=%b", $time,
                         o_out_byte, o_is_data, o_frame_end);
                errors++;
            end else begin
                exp_b = pending_bytes.pop_front();
                if (o_out_byte !== exp_b.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             exp_b.out_byte, o_out_byte);
                    errors++;
                end
                if (o_is_data !== exp_b.is_data) begin
                    $display("%0t: is_data expected %b actual %b", $time,
                             exp_b.is_data, o_is_data);
                    errors++;
                end
                if (o_frame_end !== exp_b.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             exp_b.frame_end, o_frame_end);
                    errors++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            apply_request(i_func, int'(i_x_pos), int'(i_y_pos), int'(i_rect_width),
                          int'(i_rect_height), i_clip_set, i_color_on, hb, sb);
            if (hb) pending_bytes.push_back(cur_typed ? cur_typed_byte : sb);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL page_framebuffer_draw_refresh");
            $finish;
        end
    end

    // Hold the request until taken; returns at the falling edge after the take.
    task automatic send_request(input t_req r);
        start = 1'b1;
        i_func = r.func;
        i_x_pos = r.x;
        i_y_pos = r.y;
        i_rect_width = r.w;
        i_rect_height = r.h;
        i_clip_set = r.clip;
        i_color_on = r.color;
        cur_typed = r.typed;
        cur_typed_byte = '{r.t_byte, r.t_data, r.t_end};
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Random gap: mostly none or short, now and then long.
    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5) return;
        n = (n == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        start = 1'b0;
        cur_typed = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic t_req mk(input logic [1:0] fn, input int x, input int y,
                                input int w, input int h, input bit clip, input bit on);
        t_req r;
        r = '{fn, 10'(x), 10'(y), 10'(w), 10'(h), clip, on, 1'b0, 8'h00, 1'b0, 1'b0};
        return r;
    endfunction

    function automatic t_req mk_typed(input logic [7:0] b, input bit d);
        t_req r;
        r = mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.t_byte = b;
        r.t_data = d;
        return r;
    endfunction

    function automatic t_req random_request();
        int k;
        t_req r;
        k = $urandom_range(0, 99);
        r = mk(FUNC_REFRESH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (k < 30) begin
            // pixel, mostly near the screen
            r.func = FUNC_PIXEL;
            if (k < 26) begin
                r.x = 10'($urandom_range(0, SCR_W + 5) - 3);
                r.y = 10'($urandom_range(0, SCR_H + 5) - 3);
            end
        end else if (k < 38) begin
            // fill, mostly a small clip rectangle
            r.func = FUNC_FILL;
            if (k < 36) begin
                r.clip = 1'b1;
                r.x = 10'($urandom_range(0, SCR_W + 10) - 10);
                r.y = 10'($urandom_range(0, SCR_H + 10) - 10);
                r.w = 10'($urandom_range(0, 24));
                r.h = 10'($urandom_range(0, 20));
            end else if (k == 36) begin
                r.clip = 1'b0;
            end
        end else if (k == 38) begin
            r.func = FUNC_UNUSED;
        end
        return r;
    endfunction

    t_req dir_tbl[$];

    initial begin
        errors = 0;
        cycles = 0;
        cur_typed = 1'b0;
        cur_typed_byte = '{8'h00, 1'b0, 1'b0};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = FUNC_PIXEL;
        i_x_pos = '0;
        i_y_pos = '0;
        i_rect_width = '0;
        i_rect_height = '0;
        i_clip_set = 1'b0;
        i_color_on = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++) mirror_store[i] = 8'h00;
        scan_pg = 0;
        scan_sl = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset: page 0 Y command, X command, cleared data byte.
        dir_tbl.push_back(mk_typed(CMD_SET_Y, 1'b0));
        dir_tbl.push_back(mk_typed(CMD_SET_X, 1'b0));
        dir_tbl.push_back(mk_typed(8'h00, 1'b1));
        // Corner pixels and off-screen pixels at the field extremes.
        dir_tbl.push_back(mk(FUNC_PIXEL, 0, 0, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, SCR_W - 1, SCR_H - 1, 1023, 1023, 1, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, -1, 0, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, SCR_W, 0, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, 0, SCR_H, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, -512, 511, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, 511, -512, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0));
        // Fills: whole screen, empty clips, partial pages, oversized clip.
        dir_tbl.push_back(mk(FUNC_FILL, 0, 0, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_FILL, 10, 10, 0, 20, 1, 0));
        dir_tbl.push_back(mk(FUNC_FILL, 10, 10, 20, 0, 1, 0));
        dir_tbl.push_back(mk(FUNC_FILL, 100, 60, 5, 5, 1, 0));
        dir_tbl.push_back(mk(FUNC_FILL, 3, 5, 10, 13, 1, 0));
        dir_tbl.push_back(mk(FUNC_FILL, -512, -512, 1023, 1023, 1, 0));
        dir_tbl.push_back(mk(FUNC_FILL, 1, 2, 40, 3, 1, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, 5, 7, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_PIXEL, 5, 7, 0, 0, 0, 0));
        dir_tbl.push_back(mk(FUNC_UNUSED, 0, 0, 0, 0, 0, 1));
        dir_tbl.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0));
        dir_tbl.push_back(mk(FUNC_REFRESH, 0, 0, 0, 0, 0, 0));

        foreach (dir_tbl[i]) begin
            send_request(dir_tbl[i]);
            sender_gap();
        end

        // Let everything drain before the random part.
        start = 1'b0;
        cur_typed = 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM / 2) begin
                start = 1'b0;
                while (pending_bytes.size() != 0) @(negedge i_clk);
            end
            send_request(random_request());
            // a stretch with no gaps at all
            if (i < 300 || i > 500) sender_gap();
        end

        start = 1'b0;
        cur_typed = 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS page_framebuffer_draw_refresh");
        end else begin
            $display("FAIL page_framebuffer_draw_refresh");
        end
        $finish;
    end
endmodule
